### hw/rtl/pvas_pkg.sv
// ----------------------------------------------------------------------------
// pvas_pkg
// Shared types and constants for the polar vector add/sub CORDIC pipeline.
// ----------------------------------------------------------------------------
package pvas_pkg;

  // datapath width of the CORDIC x and y words
  localparam int XY_BITS    = 44;
  // internal angle width: 32-bit binary angle plus headroom
  localparam int Z_BITS     = 34;
  // number of CORDIC micro-rotations per chain
  localparam int STEPS      = 30;
  // magnitudes are scaled to this many bits before rotation
  localparam int INNER_BITS = 36;
  // 1/K^2 in Q24
  localparam int GAIN_BITS  = 23;
  localparam logic [GAIN_BITS-1:0] INV_GAIN_SQ = 23'd6186701;
  localparam int GAIN_FRAC  = 24;
  // split of the vectored magnitude for the two partial products
  localparam int LO_BITS    = 22;
  localparam int HI_BITS    = 21;
  localparam int PROD_BITS  = 67;

  typedef logic signed [XY_BITS-1:0] xy_t;
  typedef logic signed [Z_BITS-1:0]  z_t;

  // arctangent of 2^-i as 32-bit binary angle
  function automatic z_t atan_of(input int i);
    z_t r;
    begin
      unique case (i)
        0:  r = 34'sh020000000;
        1:  r = 34'sh012E4051E;
        2:  r = 34'sh009FB385B;
        3:  r = 34'sh0051111D4;
        4:  r = 34'sh0028B0D43;
        5:  r = 34'sh00145D7E1;
        6:  r = 34'sh000A2F61E;
        7:  r = 34'sh000517C55;
        8:  r = 34'sh00028BE53;
        9:  r = 34'sh000145F2F;
        10: r = 34'sh0000A2F98;
        11: r = 34'sh0000517CC;
        12: r = 34'sh000028BE6;
        13: r = 34'sh0000145F3;
        14: r = 34'sh00000A2FA;
        15: r = 34'sh00000517D;
        16: r = 34'sh0000028BE;
        17: r = 34'sh00000145F;
        18: r = 34'sh000000A30;
        19: r = 34'sh000000518;
        20: r = 34'sh00000028C;
        21: r = 34'sh000000146;
        22: r = 34'sh0000000A3;
        23: r = 34'sh000000051;
        24: r = 34'sh000000029;
        25: r = 34'sh000000014;
        26: r = 34'sh00000000A;
        27: r = 34'sh000000005;
        28: r = 34'sh000000003;
        29: r = 34'sh000000001;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

### hw/rtl/pvas_if.sv
// ----------------------------------------------------------------------------
// pvas_if
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface pvas_req_if #(
  parameter int ANGLE_BITS = 16,
  parameter int MAG_BITS   = 16
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [ANGLE_BITS-1:0] a_angle;
  logic        [MAG_BITS-1:0]   a_mag;
  logic signed [ANGLE_BITS-1:0] b_angle;
  logic        [MAG_BITS-1:0]   b_mag;

  modport source (output valid, kind, a_angle, a_mag, b_angle, b_mag, input ready);
  modport sink   (input valid, kind, a_angle, a_mag, b_angle, b_mag, output ready);
endinterface

interface pvas_rsp_if #(
  parameter int ANGLE_BITS = 16,
  parameter int MAG_BITS   = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] sum_angle;
  logic        [MAG_BITS:0]     sum_mag;

  modport source (output valid, sum_angle, sum_mag, input ready);
  modport sink   (input valid, sum_angle, sum_mag, output ready);
endinterface

### hw/rtl/pvas_cell.sv
// ----------------------------------------------------------------------------
// pvas_cell
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module pvas_cell #(
  parameter int SHIFT     = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic           clk,
  input  logic           en,
  input  pvas_pkg::xy_t  x_in,
  input  pvas_pkg::xy_t  y_in,
  input  pvas_pkg::z_t   z_in,
  output pvas_pkg::xy_t  x_out,
  output pvas_pkg::xy_t  y_out,
  output pvas_pkg::z_t   z_out
);

  localparam pvas_pkg::z_t ATAN = pvas_pkg::atan_of(SHIFT);

  pvas_pkg::xy_t dx, dy;
  logic          ccw;

  assign dx  = y_in >>> SHIFT;
  assign dy  = x_in >>> SHIFT;
  // direction: drive z to zero, or y to zero when vectoring
  assign ccw = VECTORING ? y_in[pvas_pkg::XY_BITS-1] : !z_in[pvas_pkg::Z_BITS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ccw) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN;
      end
    end
  end

endmodule

### hw/rtl/polar_vector_add_sub.sv
// ----------------------------------------------------------------------------
// polar_vector_add_sub
// Adds or subtracts two polar vectors through pipelined CORDIC chains.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operand item (kind, a_angle, a_mag, b_angle, b_mag);
//   rsp returns one result item (sum_angle, sum_mag) per operand item, in
//   order. Both are valid/ready channels.
//   Each operand pair is turned into x/y by two parallel 30-cell rotation
//   chains, combined, and turned back by a 30-cell vectoring chain; the gain
//   is removed by a split multiply, then rounded and saturated.
//   Every stage is a register: prep, rotation cells, combine, prefold,
//   vectoring cells, product stages and output; one item per cycle while rsp takes results.
//   When rsp stalls with a result waiting, the whole pipeline holds and
//   req.ready drops; it rises again as soon as the result is taken.
//   Reset (rst, synchronous) clears the stage valid bits only; no clearing
//   pass, items may be sent in the cycle after reset drops.
// ----------------------------------------------------------------------------
module polar_vector_add_sub #(
  parameter int ANGLE_BITS = 16,
  parameter int MAG_BITS   = 16
) (
  input logic         clk,
  input logic         rst,
  pvas_req_if.sink    req,
  pvas_rsp_if.source  rsp
);

  localparam int STEPS  = pvas_pkg::STEPS;
  localparam int XW     = pvas_pkg::XY_BITS;
  localparam int ZW     = pvas_pkg::Z_BITS;
  localparam int ASH    = 32 - ANGLE_BITS;
  localparam int MSHIN  = pvas_pkg::INNER_BITS - MAG_BITS;
  localparam int MSH    = pvas_pkg::GAIN_FRAC + pvas_pkg::INNER_BITS - MAG_BITS;
  localparam int PW     = pvas_pkg::PROD_BITS;
  localparam int LO     = pvas_pkg::LO_BITS;
  localparam int HI     = pvas_pkg::HI_BITS;
  localparam int NSTG   = 2 * STEPS + 6;
  localparam logic [31:0]   AHALF = (32'(1) << ASH) >> 1;
  localparam logic [PW-1:0] MHALF = PW'(1) << (MSH - 1);
  localparam int SATLO  = MSH + MAG_BITS + 1;

  logic [NSTG-1:0] vld;
  logic            en;

  // pipeline holds while a result waits; no item taken during reset
  assign en        = !vld[NSTG-1] || rsp.ready;
  assign req.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], req.valid};
    end
  end

  // operand prep: scale magnitudes, fold angles into right half plane
  logic [31:0] az32, bz32;
  logic        afold, bfold;
  pvas_pkg::xy_t ax0, bx0;

  assign az32  = 32'(unsigned'(req.a_angle)) << ASH;
  assign bz32  = 32'(unsigned'(req.b_angle)) << ASH;
  assign afold = az32[31] ^ az32[30];
  assign bfold = bz32[31] ^ bz32[30];
  assign ax0   = XW'(req.a_mag) << MSHIN;
  assign bx0   = XW'(req.b_mag) << MSHIN;

  pvas_pkg::xy_t ax [0:STEPS];
  pvas_pkg::xy_t ay [0:STEPS];
  pvas_pkg::z_t  az [0:STEPS];
  pvas_pkg::xy_t bx [0:STEPS];
  pvas_pkg::xy_t by [0:STEPS];
  pvas_pkg::z_t  bz [0:STEPS];
  logic [STEPS:0] kind_pipe;

  always_ff @(posedge clk) begin
    if (en) begin
      ax[0]        <= afold ? -ax0 : ax0;
      ay[0]        <= '0;
      az[0]        <= ZW'(signed'({afold ^ az32[31], az32[30:0]}));
      bx[0]        <= bfold ? -bx0 : bx0;
      by[0]        <= '0;
      bz[0]        <= ZW'(signed'({bfold ^ bz32[31], bz32[30:0]}));
      kind_pipe[0] <= req.kind;
    end
  end

  // rotation chains, one per operand
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    pvas_cell #(.SHIFT(i), .VECTORING(1'b0)) u_acell (
      .clk(clk), .en(en),
      .x_in(ax[i]), .y_in(ay[i]), .z_in(az[i]),
      .x_out(ax[i+1]), .y_out(ay[i+1]), .z_out(az[i+1])
    );
    pvas_cell #(.SHIFT(i), .VECTORING(1'b0)) u_bcell (
      .clk(clk), .en(en),
      .x_in(bx[i]), .y_in(by[i]), .z_in(bz[i]),
      .x_out(bx[i+1]), .y_out(by[i+1]), .z_out(bz[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        kind_pipe[i+1] <= kind_pipe[i];
      end
    end
  end

  // combine components
  pvas_pkg::xy_t cx, cy;
  always_ff @(posedge clk) begin
    if (en) begin
      if (kind_pipe[STEPS]) begin
        cx <= ax[STEPS] - bx[STEPS];
        cy <= ay[STEPS] - by[STEPS];
      end else begin
        cx <= ax[STEPS] + bx[STEPS];
        cy <= ay[STEPS] + by[STEPS];
      end
    end
  end

  // vectoring prefold into right half plane
  pvas_pkg::xy_t vx [0:STEPS];
  pvas_pkg::xy_t vy [0:STEPS];
  pvas_pkg::z_t  vz [0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (cx[XW-1]) begin
        vx[0] <= -cx;
        vy[0] <= -cy;
        vz[0] <= ZW'(33'sh080000000);
      end else begin
        vx[0] <= cx;
        vy[0] <= cy;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    pvas_cell #(.SHIFT(i), .VECTORING(1'b1)) u_vcell (
      .clk(clk), .en(en),
      .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
      .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1])
    );
  end

  // gain removal: two partial products
  logic [LO+pvas_pkg::GAIN_BITS-1:0] p_lo;
  logic [HI+pvas_pkg::GAIN_BITS-1:0] p_hi;
  logic [31:0]                       ang_m, ang_s;
  logic [PW-1:0]                     prod;

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo  <= vx[STEPS][LO-1:0] * pvas_pkg::INV_GAIN_SQ;
      p_hi  <= vx[STEPS][LO+HI-1:LO] * pvas_pkg::INV_GAIN_SQ;
      ang_m <= vz[STEPS][31:0] + AHALF;
    end
  end

  // sum partial products with rounding
  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= PW'(p_lo) + (PW'(p_hi) << LO) + MHALF;
      ang_s <= ang_m;
    end
  end

  // shift, saturate, zero-magnitude angle
  logic [MAG_BITS:0] mag_c;
  always_comb begin
    if (|prod[PW-1:SATLO]) begin
      mag_c = '1;
    end else begin
      mag_c = prod[SATLO-1:MSH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.sum_mag   <= mag_c;
      rsp.sum_angle <= (mag_c == '0) ? '0 : signed'(ang_s[31:ASH]);
    end
  end

  assign rsp.valid = vld[NSTG-1];

endmodule
